@@ rtl/core/assert_macros.svh @@
// assertion helpers, compiled out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`define ASSERT_IMPLIES(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

`define ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, cond, msg)

`define ASSERT_IMPLIES(label, pre, post, msg)

`define ASSERT_NEXT(label, pre, post, msg)

`endif

`endif

@@ rtl/core/tcgr_pkg.sv @@
package tcgr_pkg;

    localparam int GLYPH_COUNT     = 128;
    localparam int GLYPH_ROWS      = 16;
    localparam int GLYPH_WIDTH     = 8;
    localparam int WORDS_PER_GLYPH = (GLYPH_ROWS + 3) / 4;

    localparam int FONT_W      = 32;
    localparam int STORE_DEPTH = 512;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);

    localparam int CODE_W     = 8;
    localparam int GLYPH_W    = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
    localparam int ROW_CNT_W  = $clog2(GLYPH_ROWS);
    localparam int IDX_W      = GLYPH_W + ROW_CNT_W + 3;

    localparam int COL_W      = 8;
    localparam int ROW_W      = 7;
    localparam int ROWY_W     = ROW_W + ROW_CNT_W;
    localparam int COLX_W     = COL_W + 3;

    localparam int ADDR_W     = 22;
    localparam int MASK_W     = 8;

    localparam int SW_W       = 12;
    localparam int TCOL_W     = 9;
    localparam int TROW_W     = 8;

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [SW_W-1:0]   SCREEN_WIDTH_RST = SW_W'(640);
    localparam logic [TCOL_W-1:0] TEXT_COLUMNS_RST = TCOL_W'(80);
    localparam logic [TROW_W-1:0] TEXT_ROWS_RST    = TROW_W'(30);

    localparam logic [CODE_W-1:0] NEWLINE_CODE = CODE_W'(10);

    typedef enum logic
    {
        OP_LOAD = 1'b0,
        OP_PUT  = 1'b1
    } opcode_t;

    typedef enum logic [1:0]
    {
        REG_SCREEN_WIDTH = 2'd0,
        REG_TEXT_COLUMNS = 2'd1,
        REG_TEXT_ROWS    = 2'd2
    } reg_idx_t;

endpackage

@@ rtl/core/tcgr_if.sv @@
interface tcgr_cmd_if;
    import tcgr_pkg::*;

    logic                valid;
    logic                ready;
    logic [0:0]          opcode;
    logic [STORE_AW-1:0] font_index;
    logic [FONT_W-1:0]   font_word;
    logic [CODE_W-1:0]   char_code;

    modport source
    (
        output valid, opcode, font_index, font_word, char_code,
        input  ready
    );

    modport sink
    (
        input  valid, opcode, font_index, font_word, char_code,
        output ready
    );
endinterface

interface tcgr_row_if;
    import tcgr_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] row_address;
    logic [MASK_W-1:0] row_mask;
    logic              clear_screen;
    logic              last;

    modport source
    (
        output valid, row_address, row_mask, clear_screen, last,
        input  ready
    );

    modport sink
    (
        input  valid, row_address, row_mask, clear_screen, last,
        output ready
    );
endinterface

@@ rtl/core/tcgr_ram.sv @@
module tcgr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/text_console_glyph_renderer_top.sv @@
// Draws 8x16 bitmap-font characters at a text cursor as framebuffer row writes. A load beat
// (opcode 0) writes one 32-bit word of the 512-word font store; a put beat (opcode 1) with a
// code below 128 yields 16 row beats, one per cycle unless row.ready stalls them, each with the
// pixel offset of the glyph row's leftmost pixel and its 8-bit mask (bit 0 leftmost); a code of
// 128 or more yields one beat with an empty mask. The final beat carries last and, when the
// cursor wrapped to the top, clear_screen. The single font store read port delivers one glyph
// row per cycle while the output is not stalled; the next character is taken on the cycle its
// last row is read, so characters stream back to back. Loads are taken when no glyph is in
// progress or when the last row of a glyph is read. The font store holds no defined value until
// written. Registers: screen_width at 0x0, text_columns at 0x4, text_rows at 0x8.
`include "assert_macros.svh"

module text_console_glyph_renderer_top (
    input  logic                              clk,
    input  logic                              rst_n,
    tcgr_cmd_if.sink                          cmd,
    tcgr_row_if.source                        row,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tcgr_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [tcgr_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [tcgr_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import tcgr_pkg::*;

    logic [SW_W-1:0]      screen_width_reg;
    logic [TCOL_W-1:0]    text_columns_reg;
    logic [TROW_W-1:0]    text_rows_reg;

    logic [COL_W-1:0]     cursor_col_reg, cursor_col_next;
    logic [ROW_W-1:0]     cursor_row_reg, cursor_row_next;

    logic                 busy_reg, busy_next;
    logic [ROW_CNT_W-1:0] row_cnt_reg, row_cnt_next;
    logic [GLYPH_W-1:0]   code_reg;
    logic                 glyph_reg;
    logic                 wrap_reg;
    logic [ADDR_W-1:0]    addr_reg, addr_next;

    logic                 s2_valid_reg, s2_valid_next;
    logic [ADDR_W-1:0]    s2_addr_reg;
    logic [1:0]           s2_byte_reg;
    logic                 s2_glyph_reg;
    logic                 s2_clear_reg;
    logic                 s2_last_reg;

    logic                 cfg_wr;
    reg_idx_t             cfg_idx;
    logic                 advance;
    logic                 issue;
    logic                 final_row;
    logic                 accept;
    logic                 put_acc;
    logic                 ram_we;
    logic [STORE_AW-1:0]  ram_raddr;
    logic [FONT_W-1:0]    ram_rdata;
    logic [FONT_W-1:0]    rdata_shift;

    logic                 in_glyph;
    logic [TCOL_W-1:0]    next_col;
    logic [TROW_W-1:0]    next_row;
    logic                 line_wrap;
    logic                 top_wrap;
    logic [ROWY_W-1:0]    cell_y;
    logic [ROWY_W+SW_W-1:0] cell_y_prod;
    logic [ADDR_W-1:0]    base_addr;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg <= SCREEN_WIDTH_RST;
            text_columns_reg <= TEXT_COLUMNS_RST;
            text_rows_reg    <= TEXT_ROWS_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_SCREEN_WIDTH: screen_width_reg <= pwdata[SW_W-1:0];
                REG_TEXT_COLUMNS: text_columns_reg <= pwdata[TCOL_W-1:0];
                REG_TEXT_ROWS:    text_rows_reg    <= pwdata[TROW_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_SCREEN_WIDTH: prdata = CFG_DATA_W'(screen_width_reg);
            REG_TEXT_COLUMNS: prdata = CFG_DATA_W'(text_columns_reg);
            REG_TEXT_ROWS:    prdata = CFG_DATA_W'(text_rows_reg);
            default:          prdata = '0;
        endcase
    end

    // handshake and pipeline control
    assign advance   = !s2_valid_reg || row.ready;
    assign issue     = busy_reg && advance;
    assign final_row = !glyph_reg || (row_cnt_reg == ROW_CNT_W'(GLYPH_ROWS - 1));
    assign cmd.ready = !busy_reg || (issue && final_row);
    assign accept    = cmd.valid && cmd.ready;
    assign put_acc   = accept && (cmd.opcode == OP_PUT);
    assign ram_we    = accept && (cmd.opcode == OP_LOAD);

    // cursor cell and advance
    assign in_glyph    = {1'b0, cmd.char_code} < (CODE_W + 1)'(GLYPH_COUNT);
    assign cell_y      = ROWY_W'(cursor_row_reg) * ROWY_W'(GLYPH_ROWS);
    assign cell_y_prod = (ROWY_W + SW_W)'(cell_y) * (ROWY_W + SW_W)'(screen_width_reg);
    assign base_addr   = ADDR_W'(cell_y_prod) + ADDR_W'({cursor_col_reg, 3'b000});

    assign next_col  = TCOL_W'(cursor_col_reg) + TCOL_W'(1);
    assign next_row  = TROW_W'(cursor_row_reg) + TROW_W'(1);
    assign line_wrap = (next_col >= text_columns_reg) || next_col[COL_W]
                       || (cmd.char_code == NEWLINE_CODE);
    assign top_wrap  = line_wrap && ((next_row >= text_rows_reg) || next_row[ROW_W]);

    always_comb
    begin
        cursor_col_next = cursor_col_reg;
        cursor_row_next = cursor_row_reg;
        if (put_acc)
        begin
            priority if (top_wrap)
            begin
                cursor_col_next = '0;
                cursor_row_next = '0;
            end
            else if (line_wrap)
            begin
                cursor_col_next = '0;
                cursor_row_next = next_row[ROW_W-1:0];
            end
            else
            begin
                cursor_col_next = next_col[COL_W-1:0];
            end
        end
    end

    always_comb
    begin
        busy_next    = busy_reg;
        row_cnt_next = row_cnt_reg;
        addr_next    = addr_reg;
        if (issue)
        begin
            row_cnt_next = row_cnt_reg + ROW_CNT_W'(1);
            addr_next    = addr_reg + ADDR_W'(screen_width_reg);
            if (final_row)
            begin
                busy_next = 1'b0;
            end
        end
        if (put_acc)
        begin
            busy_next    = 1'b1;
            row_cnt_next = '0;
            addr_next    = base_addr;
        end
    end

    assign s2_valid_next = advance ? issue : s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_col_reg <= '0;
            cursor_row_reg <= '0;
            busy_reg       <= 1'b0;
            row_cnt_reg    <= '0;
            s2_valid_reg   <= 1'b0;
        end
        else
        begin
            cursor_col_reg <= cursor_col_next;
            cursor_row_reg <= cursor_row_next;
            busy_reg       <= busy_next;
            row_cnt_reg    <= row_cnt_next;
            s2_valid_reg   <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        if (put_acc)
        begin
            code_reg  <= cmd.char_code[GLYPH_W-1:0];
            glyph_reg <= in_glyph;
            wrap_reg  <= top_wrap;
        end
        if (issue)
        begin
            s2_addr_reg  <= addr_reg;
            s2_byte_reg  <= row_cnt_reg[1:0];
            s2_glyph_reg <= glyph_reg;
            s2_clear_reg <= wrap_reg && final_row;
            s2_last_reg  <= final_row;
        end
    end

    // font store
    assign ram_raddr = STORE_AW'(IDX_W'(code_reg) * IDX_W'(WORDS_PER_GLYPH)
                                + IDX_W'(row_cnt_reg >> 2));

    tcgr_ram #(
        .WIDTH (FONT_W),
        .DEPTH (STORE_DEPTH)
    ) u_font_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cmd.font_index),
        .wdata (cmd.font_word),
        .re    (issue && glyph_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // output beat
    assign rdata_shift      = ram_rdata >> {s2_byte_reg, 3'b000};
    assign row.valid        = s2_valid_reg;
    assign row.row_address  = s2_addr_reg;
    assign row.row_mask     = s2_glyph_reg ? rdata_shift[MASK_W-1:0] : '0;
    assign row.clear_screen = s2_clear_reg;
    assign row.last         = s2_last_reg;

    `ASSERT_IMPLIES(a_load_not_mid_glyph, ram_we, !(busy_reg && !(issue && final_row)), "font write during glyph read")
    `ASSERT_NEXT(a_final_sets_last, issue && final_row, s2_valid_reg && s2_last_reg, "final row beat lost its last flag")
    `ASSERT_NEXT(a_stall_holds_count, busy_reg && !advance && !put_acc, $stable(row_cnt_reg), "row count moved during stall")
    `ASSERT_IMPLIES(a_clear_only_last, s2_valid_reg && s2_clear_reg, s2_last_reg, "clear flag on a beat that is not last")

endmodule
